// ===== hdl/qrs_pkg.sv =====
// Package with widths, codes and shared types of the quadratic root solver.
`default_nettype none
package qrs_pkg;
    localparam int FRAC_BITS = 16;
    localparam int CW = 32;
    localparam int PW = 2 * CW;
    localparam int DW = PW + 2;
    localparam int SUMW = DW + 1;
    localparam int SW = DW / 2;
    localparam int NW = SW + 1;
    localparam int DVW = NW + FRAC_BITS;
    localparam int DSW = CW + 1;
    localparam int TW = 16;
    localparam int IW = CW - 1;
    localparam int LANES = 3;

    typedef enum logic [1:0] {
        KIND_NONE    = 2'd0,
        KIND_EQUAL   = 2'd1,
        KIND_REAL    = 2'd2,
        KIND_COMPLEX = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind                 kind;
        logic                  zero_roots;
        logic                  a_neg;
        logic [CW-1:0]         a_mag;
        logic signed [CW-1:0]  b;
    } t_smeta;

    typedef struct packed {
        t_kind kind;
        logic  zero_roots;
        logic  neg_first;
        logic  neg_second;
    } t_dmeta;

    typedef struct packed {
        t_kind                kind;
        logic signed [CW-1:0] first;
        logic signed [CW-1:0] second;
        logic [IW-1:0]        imag;
    } t_result;
endpackage
`default_nettype wire

// ===== hdl/qrs_front.sv =====
// Front pipeline: magnitudes, products, discriminant and classification.
`default_nettype none
module qrs_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic signed [qrs_pkg::CW-1:0] i_a,
    input  logic signed [qrs_pkg::CW-1:0] i_b,
    input  logic signed [qrs_pkg::CW-1:0] i_c,
    input  logic [qrs_pkg::TW-1:0]        i_tol,
    output logic                          o_valid,
    output logic [qrs_pkg::DW-1:0]        o_disc,
    output qrs_pkg::t_smeta               o_meta
);
    import qrs_pkg::*;

    typedef struct packed {
        logic signed [CW-1:0] b;
        logic [CW-1:0]        a_mag;
        logic                 a_neg;
        logic                 add;
        logic                 a_small;
        logic                 bc_small;
    } t_fcarry;

    logic             r1_valid, r2_valid, r3_valid, r4_valid, r5_valid;
    logic [CW-1:0]    r1_bm, r1_cm;
    t_fcarry          r1_carry, r2_carry, r3_carry, r4_carry;
    t_fcarry          n_carry;
    logic [CW-1:0]    n_bm, n_cm;
    logic [PW-1:0]    r2_q, r2_p;
    logic [SUMW-1:0]  r3_sum;
    logic [DW-1:0]    r4_dmag;
    logic             r4_dneg;
    logic [DW-1:0]    r5_disc;
    t_smeta           r5_meta;
    t_smeta           n_meta;
    logic [DW-1:0]    tolw;
    logic [DW-1:0]    p4;
    logic [SUMW-1:0]  neg_sum;

    always_comb begin
        n_carry.b = i_b;
        n_carry.a_neg = i_a[CW-1];
        n_carry.a_mag = i_a[CW-1] ? (~i_a + 1'b1) : i_a;
        n_bm = i_b[CW-1] ? (~i_b + 1'b1) : i_b;
        n_cm = i_c[CW-1] ? (~i_c + 1'b1) : i_c;
        n_carry.add = (i_a == '0) || (i_c == '0) || (i_a[CW-1] != i_c[CW-1]);
        n_carry.a_small = n_carry.a_mag <= CW'(i_tol);
        n_carry.bc_small = (n_bm <= CW'(i_tol)) && (n_cm <= CW'(i_tol));
    end

    assign p4 = {r2_p, 2'b00};
    assign neg_sum = ~r3_sum + 1'b1;
    assign tolw = DW'(i_tol) << FRAC_BITS;

    always_comb begin
        n_meta.a_neg = r4_carry.a_neg;
        n_meta.a_mag = r4_carry.a_mag;
        n_meta.b = r4_carry.b;
        n_meta.zero_roots = 1'b0;
        if (r4_carry.a_small) begin
            n_meta.kind = KIND_NONE;
            n_meta.zero_roots = 1'b1;
        end else if (r4_carry.bc_small) begin
            n_meta.kind = KIND_EQUAL;
            n_meta.zero_roots = 1'b1;
        end else if (r4_dmag <= tolw) begin
            n_meta.kind = KIND_EQUAL;
        end else if (r4_dneg) begin
            n_meta.kind = KIND_COMPLEX;
        end else begin
            n_meta.kind = KIND_REAL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
            r5_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
            r5_valid <= r4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_carry <= n_carry;
            r1_bm <= n_bm;
            r1_cm <= n_cm;
            r2_carry <= r1_carry;
            r2_q <= PW'(r1_bm) * PW'(r1_bm);
            r2_p <= PW'(r1_carry.a_mag) * PW'(r1_cm);
            r3_carry <= r2_carry;
            r3_sum <= r2_carry.add ? (SUMW'(r2_q) + SUMW'(p4)) : (SUMW'(r2_q) - SUMW'(p4));
            r4_carry <= r3_carry;
            r4_dneg <= !r3_carry.add && r3_sum[SUMW-1];
            r4_dmag <= r3_sum[SUMW-1] ? neg_sum[DW-1:0] : r3_sum[DW-1:0];
            r5_disc <= r4_dmag;
            r5_meta <= n_meta;
        end
    end

    assign o_valid = r5_valid;
    assign o_disc = r5_disc;
    assign o_meta = r5_meta;
endmodule
`default_nettype wire

// ===== hdl/qrs_sqrt.sv =====
// Pipelined integer square root, one result bit per stage.
`default_nettype none
module qrs_sqrt (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  logic [qrs_pkg::DW-1:0] i_rad,
    input  qrs_pkg::t_smeta        i_meta,
    output logic                   o_valid,
    output logic [qrs_pkg::SW-1:0] o_root,
    output qrs_pkg::t_smeta        o_meta
);
    import qrs_pkg::*;

    logic          r_valid [SW];
    logic [SW-1:0] r_root  [SW];
    logic [DW-1:0] r_rem   [SW];
    t_smeta        r_meta  [SW];

    for (genvar j = 0; j < SW; j++) begin : g_stage
        localparam int BIT = SW - 1 - j;
        logic          p_valid;
        logic [SW-1:0] p_root;
        logic [DW-1:0] p_rem;
        t_smeta        p_meta;
        logic [DW-1:0] trial;

        if (j == 0) begin : g_first
            assign p_valid = i_valid;
            assign p_root = '0;
            assign p_rem = i_rad;
            assign p_meta = i_meta;
        end else begin : g_next
            assign p_valid = r_valid[j-1];
            assign p_root = r_root[j-1];
            assign p_rem = r_rem[j-1];
            assign p_meta = r_meta[j-1];
        end

        // Remainder minus (2*root + 2^bit) * 2^bit decides this root bit.
        assign trial = (DW'(p_root) << (BIT + 1)) | (DW'(1) << (2 * BIT));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[j] <= 1'b0;
            end else if (i_en) begin
                r_valid[j] <= p_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_meta[j] <= p_meta;
                if (p_rem >= trial) begin
                    r_rem[j] <= p_rem - trial;
                    r_root[j] <= p_root | (SW'(1) << BIT);
                end else begin
                    r_rem[j] <= p_rem;
                    r_root[j] <= p_root;
                end
            end
        end
    end

    assign o_valid = r_valid[SW-1];
    assign o_root = r_root[SW-1];
    assign o_meta = r_meta[SW-1];
endmodule
`default_nettype wire

// ===== hdl/qrs_div.sv =====
// Numerator forming and three pipelined restoring dividers by 2|a|.
`default_nettype none
module qrs_div (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic [qrs_pkg::SW-1:0]  i_root,
    input  qrs_pkg::t_smeta         i_meta,
    output logic                    o_valid,
    output logic [qrs_pkg::DVW-1:0] o_quot [qrs_pkg::LANES],
    output qrs_pkg::t_dmeta         o_meta
);
    import qrs_pkg::*;

    logic signed [NW:0] sb, seff, num1, num2;
    logic [NW:0]        abs1, abs2;
    logic [NW-1:0]      n_mag [LANES];
    t_dmeta             n_meta;

    logic               r_e_valid;
    logic [DVW-1:0]     r_e_dvd [LANES];
    logic [DSW-1:0]     r_e_dsr;
    t_dmeta             r_e_meta;

    logic               r_valid [DVW];
    logic [DSW-1:0]     r_dsr   [DVW];
    t_dmeta             r_meta  [DVW];
    logic [DSW-1:0]     r_rem   [DVW][LANES];
    logic [DVW-1:0]     r_qd    [DVW][LANES];

    always_comb begin
        sb = (NW+1)'(i_meta.b);
        // The root only shifts the numerators when the roots are real and distinct.
        seff = (i_meta.kind == KIND_REAL) ? (NW+1)'(i_root) : '0;
        num1 = seff - sb;
        num2 = -sb - seff;
        abs1 = num1[NW] ? (~num1 + 1'b1) : num1;
        abs2 = num2[NW] ? (~num2 + 1'b1) : num2;
        n_mag[0] = abs1[NW-1:0];
        n_mag[1] = abs2[NW-1:0];
        n_mag[2] = NW'(i_root);
        n_meta.kind = i_meta.kind;
        n_meta.zero_roots = i_meta.zero_roots;
        n_meta.neg_first = num1[NW] ^ i_meta.a_neg;
        n_meta.neg_second = num2[NW] ^ i_meta.a_neg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
        end else if (i_en) begin
            r_e_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < LANES; k++) begin
                r_e_dvd[k] <= {n_mag[k], {FRAC_BITS{1'b0}}};
            end
            r_e_dsr <= {i_meta.a_mag, 1'b0};
            r_e_meta <= n_meta;
        end
    end

    for (genvar j = 0; j < DVW; j++) begin : g_stage
        logic           p_valid;
        logic [DSW-1:0] p_dsr;
        t_dmeta         p_meta;

        if (j == 0) begin : g_first
            assign p_valid = r_e_valid;
            assign p_dsr = r_e_dsr;
            assign p_meta = r_e_meta;
        end else begin : g_next
            assign p_valid = r_valid[j-1];
            assign p_dsr = r_dsr[j-1];
            assign p_meta = r_meta[j-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[j] <= 1'b0;
            end else if (i_en) begin
                r_valid[j] <= p_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dsr[j] <= p_dsr;
                r_meta[j] <= p_meta;
            end
        end

        for (genvar k = 0; k < LANES; k++) begin : g_lane
            logic [DSW-1:0] p_rem;
            logic [DVW-1:0] p_qd;
            logic [DSW:0]   top;
            logic [DSW:0]   diff;

            if (j == 0) begin : g_first
                assign p_rem = '0;
                assign p_qd = r_e_dvd[k];
            end else begin : g_next
                assign p_rem = r_rem[j-1][k];
                assign p_qd = r_qd[j-1][k];
            end

            assign top = {p_rem, p_qd[DVW-1]};
            assign diff = top - {1'b0, p_dsr};

            // Dividend bits leave at the top while quotient bits enter at the bottom.
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    if (top >= {1'b0, p_dsr}) begin
                        r_rem[j][k] <= diff[DSW-1:0];
                        r_qd[j][k] <= {p_qd[DVW-2:0], 1'b1};
                    end else begin
                        r_rem[j][k] <= top[DSW-1:0];
                        r_qd[j][k] <= {p_qd[DVW-2:0], 1'b0};
                    end
                end
            end
        end
    end

    assign o_valid = r_valid[DVW-1];
    assign o_meta = r_meta[DVW-1];
    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            o_quot[k] = r_qd[DVW-1][k];
        end
    end
endmodule
`default_nettype wire

// ===== hdl/qrs_back.sv =====
// Saturation, root ordering and output skid buffer.
`default_nettype none
module qrs_back (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  logic [qrs_pkg::DVW-1:0] i_quot [qrs_pkg::LANES],
    input  qrs_pkg::t_dmeta         i_meta,
    input  logic                    i_out_stall,
    output logic                    o_en,
    output logic                    o_out_valid,
    output qrs_pkg::t_result        o_result
);
    import qrs_pkg::*;

    localparam logic [DVW-1:0] NEG_LIM = DVW'(64'h8000_0000);
    localparam logic [DVW-1:0] POS_LIM = DVW'(64'h7FFF_FFFF);

    logic                 r_b1_valid;
    logic signed [CW-1:0] r_b1_r1, r_b1_r2;
    logic [IW-1:0]        r_b1_im;
    t_dmeta               r_b1_meta;
    logic signed [CW-1:0] n_r1, n_r2;
    logic [IW-1:0]        n_im;
    t_result              n_res;

    logic                 r_out_valid, r_skid_valid;
    t_result              r_out, r_skid;
    logic                 en, take, incoming;

    function automatic logic signed [CW-1:0] sat_root(input logic [DVW-1:0] q, input logic neg);
        logic signed [CW-1:0] v;
        if (neg) begin
            v = (q > NEG_LIM) ? CW'(NEG_LIM) : (~q[CW-1:0] + 1'b1);
        end else begin
            v = (q > POS_LIM) ? CW'(POS_LIM) : q[CW-1:0];
        end
        return v;
    endfunction

    always_comb begin
        n_r1 = sat_root(i_quot[0], i_meta.neg_first);
        n_r2 = sat_root(i_quot[1], i_meta.neg_second);
        n_im = (i_quot[2] > POS_LIM) ? IW'(POS_LIM) : i_quot[2][IW-1:0];
    end

    assign en = !r_skid_valid;
    assign take = r_out_valid && !i_out_stall;
    assign incoming = en && r_b1_valid;

    always_comb begin
        n_res.kind = r_b1_meta.kind;
        if (r_b1_meta.zero_roots) begin
            n_res.first = '0;
            n_res.second = '0;
        end else if (r_b1_r1 > r_b1_r2) begin
            n_res.first = r_b1_r1;
            n_res.second = r_b1_r2;
        end else begin
            n_res.first = r_b1_r2;
            n_res.second = r_b1_r1;
        end
        n_res.imag = (r_b1_meta.kind == KIND_COMPLEX) ? r_b1_im : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_valid <= 1'b0;
        end else if (en) begin
            r_b1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b1_r1 <= n_r1;
            r_b1_r2 <= n_r2;
            r_b1_im <= n_im;
            r_b1_meta <= i_meta;
        end
    end

    // The skid register catches the transaction that arrives while the output waits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || take) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
                r_out_valid <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out <= n_res;
                r_out_valid <= incoming;
            end
        end else if (incoming) begin
            r_skid <= n_res;
            r_skid_valid <= 1'b1;
        end
    end

    assign o_en = en;
    assign o_out_valid = r_out_valid;
    assign o_result = r_out;
endmodule
`default_nettype wire

// ===== hdl/quadratic_root_solver_top.sv =====
// Top level of the quadratic root solver: configuration register and pipeline.
//
//  Channel   Signals                                     Direction
//  config    i_cfg_valid, o_cfg_ready, i_cfg_data        write, valid/ready
//  input     i_in_valid, o_in_stall, coefficients a b c  in, valid/stall
//  output    o_out_valid, i_out_stall, kind and roots    out, valid/stall
//
// One transaction enters per cycle while o_in_stall is low. Each result passes
// through five front stages, 33 square root stages, one numerator stage, 50
// divider stages, one saturation stage and the output register.
// Reset clears the valid bits and sets the tolerance to zero; no clearing pass.
// o_in_stall rises only while both the output register and the skid register hold
// results, and then the whole pipeline holds.
`default_nettype none
module quadratic_root_solver_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [qrs_pkg::TW-1:0]        i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic signed [qrs_pkg::CW-1:0] i_coef_square,
    input  logic signed [qrs_pkg::CW-1:0] i_coef_linear,
    input  logic signed [qrs_pkg::CW-1:0] i_coef_constant,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [1:0]                    o_root_kind,
    output logic signed [qrs_pkg::CW-1:0] o_first_real,
    output logic signed [qrs_pkg::CW-1:0] o_second_real,
    output logic [qrs_pkg::IW-1:0]        o_imag_magnitude
);
    import qrs_pkg::*;

    logic [TW-1:0]  r_tol;
    logic           en;
    logic           f_valid, s_valid, d_valid;
    logic [DW-1:0]  f_disc;
    t_smeta         f_meta, s_meta;
    logic [SW-1:0]  s_root;
    logic [DVW-1:0] d_quot [LANES];
    t_dmeta         d_meta;
    t_result        res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= '0;
        end else if (i_cfg_valid) begin
            r_tol <= i_cfg_data;
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_in_stall = !en;

    qrs_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in_valid),
        .i_a     (i_coef_square),
        .i_b     (i_coef_linear),
        .i_c     (i_coef_constant),
        .i_tol   (r_tol),
        .o_valid (f_valid),
        .o_disc  (f_disc),
        .o_meta  (f_meta)
    );

    qrs_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (f_valid),
        .i_rad   (f_disc),
        .i_meta  (f_meta),
        .o_valid (s_valid),
        .o_root  (s_root),
        .o_meta  (s_meta)
    );

    qrs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (s_valid),
        .i_root  (s_root),
        .i_meta  (s_meta),
        .o_valid (d_valid),
        .o_quot  (d_quot),
        .o_meta  (d_meta)
    );

    qrs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (d_valid),
        .i_quot      (d_quot),
        .i_meta      (d_meta),
        .i_out_stall (i_out_stall),
        .o_en        (en),
        .o_out_valid (o_out_valid),
        .o_result    (res)
    );

    assign o_root_kind = res.kind;
    assign o_first_real = res.first;
    assign o_second_real = res.second;
    assign o_imag_magnitude = res.imag;
endmodule
`default_nettype wire

// ===== hdl/qrs_checker.sv =====
// Port checker for the quadratic root solver and its bind statement.
`default_nettype none
module qrs_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic [1:0]                    o_root_kind,
    input logic signed [qrs_pkg::CW-1:0] o_first_real,
    input logic signed [qrs_pkg::CW-1:0] o_second_real,
    input logic [qrs_pkg::IW-1:0]        o_imag_magnitude
);
    import qrs_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_root_kind)
            && $stable(o_first_real) && $stable(o_second_real)))
        else $error("stalled result changed");

    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_root_kind == KIND_NONE) |->
            (o_first_real == '0 && o_second_real == '0 && o_imag_magnitude == '0))
        else $error("non-quadratic result carries roots");

    a_imag_only_complex: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_root_kind != KIND_COMPLEX) |-> (o_imag_magnitude == '0))
        else $error("imaginary part on a real result");

    a_real_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_root_kind == KIND_REAL) |-> (o_first_real >= o_second_real))
        else $error("distinct roots out of order");

    a_pair_equal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_root_kind == KIND_EQUAL || o_root_kind == KIND_COMPLEX))
            |-> (o_first_real == o_second_real))
        else $error("real parts of a pair differ");
endmodule

bind quadratic_root_solver_top qrs_checker u_qrs_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_root_kind      (o_root_kind),
    .o_first_real     (o_first_real),
    .o_second_real    (o_second_real),
    .o_imag_magnitude (o_imag_magnitude)
);
`default_nettype wire
